/* hdl/sbll_pkg.sv */
`default_nettype none

package sbll_pkg;

  // Bins per frame that are taken into account; later bins are ignored.
  localparam int BIN_COUNT = 256;
  localparam int IDX_W     = $clog2(BIN_COUNT + 1);

  localparam int BAND_COUNT = 3;
  localparam int BAND_W     = 2;
  localparam int BIN_W      = 8;
  localparam int MAG_W      = 16;
  localparam int SUM_W      = 24;
  localparam int LVL_W      = 8;
  localparam int SCALE_W    = 8;
  localparam int CNT_W      = BIN_W + 1;

  // Shared multiplier operands and the divider word widths.
  localparam int MUL_A_W = SUM_W;
  localparam int MUL_B_W = MAG_W;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int NUM_W   = SUM_W + SCALE_W;
  localparam int DEN_W   = CNT_W + MAG_W;
  localparam int STEP_W  = $clog2(NUM_W);

  localparam logic [LVL_W-1:0] LEVEL_CLAMP = LVL_W'(250);

  // Configuration register indexes.
  localparam int CFG_ADDR_W = 5;
  localparam logic [2:0] REG_BASS_FIRST = 3'd0;
  localparam logic [2:0] REG_BASS_LAST  = 3'd1;
  localparam logic [2:0] REG_MID_FIRST  = 3'd2;
  localparam logic [2:0] REG_MID_LAST   = 3'd3;
  localparam logic [2:0] REG_HIGH_FIRST = 3'd4;
  localparam logic [2:0] REG_HIGH_LAST  = 3'd5;

  // Band indexes.
  localparam logic [BAND_W-1:0] BAND_BASS = 2'd0;
  localparam logic [BAND_W-1:0] BAND_MID  = 2'd1;
  localparam logic [BAND_W-1:0] BAND_HIGH = 2'd2;

  typedef struct packed {
    logic [BAND_COUNT-1:0][BIN_W-1:0] first;
    logic [BAND_COUNT-1:0][BIN_W-1:0] last;
  } band_cfg_t;

  typedef enum logic [1:0] {
    ARITH_HOLD,
    ARITH_LOAD_NUM,
    ARITH_LOAD_DEN,
    ARITH_DIV_STEP
  } arith_op_t;

  typedef struct packed {
    arith_op_t            op;
    logic [MUL_A_W-1:0]   mul_a;
    logic [MUL_B_W-1:0]   mul_b;
  } arith_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_NUM,
    ST_MUL_DEN,
    ST_DIV,
    ST_LEVEL,
    ST_OUT
  } state_t;

  // Brightness scale of each band.
  function automatic logic [SCALE_W-1:0] band_scale(input logic [BAND_W-1:0] b);
    logic [SCALE_W-1:0] s;
    case (b)
      BAND_BASS: s = SCALE_W'(100);
      BAND_MID:  s = SCALE_W'(100);
      BAND_HIGH: s = SCALE_W'(255);
      default:   s = '0;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

/* hdl/spectrum_band_light_levels.sv */
// Spectrum band light levels. Magnitude bins of one frame stream in on the
// in_ channel in index order, one request per cycle while in_stall is low,
// and are summed into the bass, mid and high bands set through the cfg_
// registers while a peak is tracked. A bin that is not the frame's last does
// not stall the input. The request carrying frame_end starts the level
// calculation, during which in_stall is high: for each of the three bands one
// shared multiplier forms sum*scale and then count*peak, a restoring divider
// makes 32 quotient steps of one bit each, and the ST_LEVEL state smooths and
// clamps the level; then the ST_OUT state hands the result to the output
// register once the previous result has left it. The result then sits on the
// out_ channel until it is taken, while the next frame's bins are already
// accepted.
`default_nettype none

module spectrum_band_light_levels (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [15:0]                     in_magnitude,
  input  wire logic                            in_frame_end,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [7:0]                           out_blue_level,
  output logic [7:0]                           out_green_level,
  output logic [7:0]                           out_red_level,
  output logic                                 out_degenerate,
  input  wire logic                            cfg_psel,
  input  wire logic                            cfg_penable,
  input  wire logic                            cfg_pwrite,
  input  wire logic [sbll_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [31:0]                     cfg_pwdata,
  output logic      [31:0]                     cfg_prdata,
  output logic                                 cfg_pready
);

  sbll_pkg::band_cfg_t  band_cfg;
  sbll_pkg::arith_req_t arith_req;
  sbll_pkg::state_t     state_r, state_nxt;

  logic [sbll_pkg::BAND_COUNT-1:0][sbll_pkg::SUM_W-1:0] sums;
  logic [sbll_pkg::MAG_W-1:0]  peak;
  logic [sbll_pkg::NUM_W-1:0]  quotient;
  logic [sbll_pkg::BAND_W-1:0] band_r;
  logic [sbll_pkg::STEP_W-1:0] step_r;
  logic                        deg_r;
  logic [sbll_pkg::BAND_COUNT-1:0][sbll_pkg::LVL_W-1:0] prev_r;
  logic                        out_valid_r;
  logic [sbll_pkg::BAND_COUNT-1:0][sbll_pkg::LVL_W-1:0] out_lvl_r;
  logic                        out_deg_r;

  logic                        take;
  logic                        clear;
  logic                        band_deg;
  logic [sbll_pkg::BIN_W-1:0]  first_sel, last_sel;
  logic [sbll_pkg::CNT_W-1:0]  count;
  logic [sbll_pkg::NUM_W-1:0]  raw;
  logic [sbll_pkg::NUM_W:0]    lvl_sum;
  logic [sbll_pkg::NUM_W-1:0]  avg;
  logic [sbll_pkg::LVL_W-1:0]  level;
  logic                        out_free;

  sbll_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .band_cfg    (band_cfg)
  );

  sbll_accum u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .magnitude (in_magnitude),
    .clear     (clear),
    .band_cfg  (band_cfg),
    .sums      (sums),
    .peak      (peak)
  );

  sbll_arith u_arith (
    .clk      (clk),
    .req      (arith_req),
    .quotient (quotient)
  );

  assign in_stall = (state_r != sbll_pkg::ST_IDLE);
  assign take     = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // Band under calculation: its range, bin count and whether it is degenerate.
  always_comb begin
    first_sel = band_cfg.first[band_r];
    last_sel  = band_cfg.last[band_r];
    count     = sbll_pkg::CNT_W'(last_sel) - sbll_pkg::CNT_W'(first_sel) + 1'b1;
    band_deg  = (first_sel > last_sel) || (peak == '0);
    raw       = band_deg ? '0 : quotient;
    lvl_sum   = {1'b0, raw} + (sbll_pkg::NUM_W + 1)'(prev_r[band_r]);
    avg       = lvl_sum[sbll_pkg::NUM_W:1];
    level     = (avg >= sbll_pkg::NUM_W'(sbll_pkg::LEVEL_CLAMP)) ?
                sbll_pkg::LEVEL_CLAMP : avg[sbll_pkg::LVL_W-1:0];
  end

  // Sequencer: next state and requests to the shared unit.
  always_comb begin
    state_nxt       = state_r;
    arith_req.op    = sbll_pkg::ARITH_HOLD;
    arith_req.mul_a = sums[band_r];
    arith_req.mul_b = sbll_pkg::MUL_B_W'(sbll_pkg::band_scale(band_r));
    clear           = 1'b0;
    case (state_r)
      sbll_pkg::ST_IDLE: begin
        if (take && in_frame_end) begin
          state_nxt = sbll_pkg::ST_MUL_NUM;
        end
      end
      sbll_pkg::ST_MUL_NUM: begin
        arith_req.op = sbll_pkg::ARITH_LOAD_NUM;
        state_nxt    = sbll_pkg::ST_MUL_DEN;
      end
      sbll_pkg::ST_MUL_DEN: begin
        arith_req.op    = sbll_pkg::ARITH_LOAD_DEN;
        arith_req.mul_a = sbll_pkg::MUL_A_W'(peak);
        arith_req.mul_b = sbll_pkg::MUL_B_W'(count);
        state_nxt       = sbll_pkg::ST_DIV;
      end
      sbll_pkg::ST_DIV: begin
        arith_req.op = sbll_pkg::ARITH_DIV_STEP;
        if (step_r == sbll_pkg::STEP_W'(sbll_pkg::NUM_W - 1)) begin
          state_nxt = sbll_pkg::ST_LEVEL;
        end
      end
      sbll_pkg::ST_LEVEL: begin
        if (band_r == sbll_pkg::BAND_HIGH) begin
          state_nxt = sbll_pkg::ST_OUT;
        end else begin
          state_nxt = sbll_pkg::ST_MUL_NUM;
        end
      end
      sbll_pkg::ST_OUT: begin
        if (out_free) begin
          clear     = 1'b1;
          state_nxt = sbll_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sbll_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sbll_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Band and step counters, degenerate flag and smoothed levels.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      band_r <= '0;
      step_r <= '0;
      deg_r  <= 1'b0;
      prev_r <= '0;
    end else begin
      case (state_r)
        sbll_pkg::ST_IDLE: begin
          band_r <= sbll_pkg::BAND_BASS;
          deg_r  <= 1'b0;
        end
        sbll_pkg::ST_MUL_DEN: begin
          step_r <= '0;
        end
        sbll_pkg::ST_DIV: begin
          step_r <= step_r + 1'b1;
        end
        sbll_pkg::ST_LEVEL: begin
          prev_r[band_r] <= level;
          deg_r          <= deg_r || band_deg;
          band_r         <= band_r + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Output register: loaded when the slot is free, emptied when taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (clear) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (clear) begin
      out_lvl_r <= prev_r;
      out_deg_r <= deg_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_blue_level  = out_lvl_r[0];
  assign out_green_level = out_lvl_r[1];
  assign out_red_level   = out_lvl_r[2];
  assign out_degenerate  = out_deg_r;

endmodule

`default_nettype wire

/* hdl/sbll_cfg.sv */
`default_nettype none

module sbll_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_psel,
  input  wire logic                           cfg_penable,
  input  wire logic                           cfg_pwrite,
  input  wire logic [sbll_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [31:0]                    cfg_pwdata,
  output logic      [31:0]                    cfg_prdata,
  output logic                                cfg_pready,
  output sbll_pkg::band_cfg_t                 band_cfg
);

  sbll_pkg::band_cfg_t cfg_r;
  logic [2:0]          reg_idx;
  logic                wr_en;
  logic [sbll_pkg::BIN_W-1:0] rd_val;

  assign reg_idx    = cfg_paddr[4:2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign band_cfg   = cfg_r;

  // Register writes; an index past the list is dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.first[0] <= 8'd0;
      cfg_r.last[0]  <= 8'd9;
      cfg_r.first[1] <= 8'd10;
      cfg_r.last[1]  <= 8'd30;
      cfg_r.first[2] <= 8'd40;
      cfg_r.last[2]  <= 8'd250;
    end else if (wr_en) begin
      case (reg_idx)
        sbll_pkg::REG_BASS_FIRST: cfg_r.first[0] <= cfg_pwdata[7:0];
        sbll_pkg::REG_BASS_LAST:  cfg_r.last[0]  <= cfg_pwdata[7:0];
        sbll_pkg::REG_MID_FIRST:  cfg_r.first[1] <= cfg_pwdata[7:0];
        sbll_pkg::REG_MID_LAST:   cfg_r.last[1]  <= cfg_pwdata[7:0];
        sbll_pkg::REG_HIGH_FIRST: cfg_r.first[2] <= cfg_pwdata[7:0];
        sbll_pkg::REG_HIGH_LAST:  cfg_r.last[2]  <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read back of the addressed register.
  always_comb begin
    case (reg_idx)
      sbll_pkg::REG_BASS_FIRST: rd_val = cfg_r.first[0];
      sbll_pkg::REG_BASS_LAST:  rd_val = cfg_r.last[0];
      sbll_pkg::REG_MID_FIRST:  rd_val = cfg_r.first[1];
      sbll_pkg::REG_MID_LAST:   rd_val = cfg_r.last[1];
      sbll_pkg::REG_HIGH_FIRST: rd_val = cfg_r.first[2];
      sbll_pkg::REG_HIGH_LAST:  rd_val = cfg_r.last[2];
      default:                  rd_val = '0;
    endcase
    cfg_prdata = {24'd0, rd_val};
  end

endmodule

`default_nettype wire

/* hdl/sbll_accum.sv */
`default_nettype none

module sbll_accum (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        take,
  input  wire logic [sbll_pkg::MAG_W-1:0]  magnitude,
  input  wire logic                        clear,
  input  sbll_pkg::band_cfg_t              band_cfg,
  output logic [sbll_pkg::BAND_COUNT-1:0][sbll_pkg::SUM_W-1:0] sums,
  output logic [sbll_pkg::MAG_W-1:0]       peak
);

  logic [sbll_pkg::IDX_W-1:0] idx_r, idx_nxt;
  logic [sbll_pkg::BAND_COUNT-1:0][sbll_pkg::SUM_W-1:0] sums_r, sums_nxt;
  logic [sbll_pkg::MAG_W-1:0] peak_r, peak_nxt;
  logic [sbll_pkg::MAG_W-1:0] mag_eff;
  logic [sbll_pkg::BAND_COUNT-1:0] hit;
  logic                       active;

  assign sums = sums_r;
  assign peak = peak_r;

  // Per-bin update: band membership uses the registers in force now.
  always_comb begin
    active   = take && (idx_r < sbll_pkg::IDX_W'(sbll_pkg::BIN_COUNT));
    mag_eff  = (idx_r == '0) ? '0 : magnitude;
    idx_nxt  = idx_r;
    sums_nxt = sums_r;
    peak_nxt = peak_r;
    for (int b = 0; b < sbll_pkg::BAND_COUNT; b++) begin
      hit[b] = (idx_r >= sbll_pkg::IDX_W'(band_cfg.first[b])) &&
               (idx_r <= sbll_pkg::IDX_W'(band_cfg.last[b]));
      if (active && hit[b]) begin
        sums_nxt[b] = sums_r[b] + sbll_pkg::SUM_W'(mag_eff);
      end
    end
    if (active) begin
      idx_nxt = idx_r + 1'b1;
      if (((|hit) || (idx_r == sbll_pkg::IDX_W'(1))) && (mag_eff > peak_r)) begin
        peak_nxt = mag_eff;
      end
    end
    if (clear) begin
      idx_nxt  = '0;
      sums_nxt = '0;
      peak_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= '0;
      sums_r <= '0;
      peak_r <= '0;
    end else begin
      idx_r  <= idx_nxt;
      sums_r <= sums_nxt;
      peak_r <= peak_nxt;
    end
  end

endmodule

`default_nettype wire

/* hdl/sbll_arith.sv */
`default_nettype none

module sbll_arith (
  input  wire logic                       clk,
  input  sbll_pkg::arith_req_t            req,
  output logic [sbll_pkg::NUM_W-1:0]      quotient
);

  logic [sbll_pkg::PROD_W-1:0] product;
  logic [sbll_pkg::NUM_W-1:0]  quo_r;
  logic [sbll_pkg::DEN_W-1:0]  rem_r;
  logic [sbll_pkg::DEN_W-1:0]  den_r;
  logic [sbll_pkg::DEN_W:0]    shifted;
  logic [sbll_pkg::DEN_W:0]    diff;

  assign quotient = quo_r;

  // Shared multiplier, used once for the numerator and once for the divisor.
  assign product = req.mul_a * req.mul_b;

  // One restoring division step: shift in the next dividend bit, try to subtract.
  assign shifted = {rem_r, quo_r[sbll_pkg::NUM_W-1]};
  assign diff    = shifted - {1'b0, den_r};

  always_ff @(posedge clk) begin
    case (req.op)
      sbll_pkg::ARITH_LOAD_NUM: begin
        quo_r <= product[sbll_pkg::NUM_W-1:0];
        rem_r <= '0;
      end
      sbll_pkg::ARITH_LOAD_DEN: begin
        den_r <= product[sbll_pkg::DEN_W-1:0];
      end
      sbll_pkg::ARITH_DIV_STEP: begin
        if (!diff[sbll_pkg::DEN_W]) begin
          rem_r <= diff[sbll_pkg::DEN_W-1:0];
          quo_r <= {quo_r[sbll_pkg::NUM_W-2:0], 1'b1};
        end else begin
          rem_r <= shifted[sbll_pkg::DEN_W-1:0];
          quo_r <= {quo_r[sbll_pkg::NUM_W-2:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

/* hdl/sbll_checker.sv */
`default_nettype none

module sbll_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_valid,
  input wire logic                            in_stall,
  input wire logic                            in_frame_end,
  input wire logic                            out_valid,
  input wire logic                            out_stall,
  input wire logic [7:0]                      out_blue_level,
  input wire logic [7:0]                      out_green_level,
  input wire logic [7:0]                      out_red_level,
  input wire logic                            out_degenerate
);

  // A frame end request starts the level calculation, which holds off input.
  a_frame_end_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_frame_end) |=> in_stall)
    else $error("input not stalled after a frame end request");

  // Ordinary bins stream at one per cycle.
  a_bin_streams: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && !in_frame_end) |=> !in_stall)
    else $error("input stalled after an ordinary bin");

  // Levels never exceed the clamp.
  a_level_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_blue_level <= 8'd250 && out_green_level <= 8'd250 &&
                   out_red_level <= 8'd250))
    else $error("level above clamp");

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_blue_level) &&
      $stable(out_green_level) && $stable(out_red_level) &&
      $stable(out_degenerate)))
    else $error("stalled result changed");

endmodule

bind spectrum_band_light_levels sbll_checker u_sbll_checker (.*);

`default_nettype wire
